// ===== sv/ssqe_pkg.sv =====
// ----------------------------------------------------------------------------
// ssqe_pkg
// Shared types and constants of the segment snap query engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssqe_pkg;

	localparam int MAX_VERTICES_DEF = 256;
	localparam int MAX_EDGES_DEF    = 256;
	localparam int COORD_WIDTH_DEF  = 24;

	localparam int RADIUS_W     = 23;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd2560;
	localparam int DIR_W        = 16;
	localparam int DIR_FRAC     = 14;
	localparam int UFRAC        = 30;
	localparam int FIRST_IDX_W  = 9;
	localparam int SECOND_IDX_W = 8;
	localparam int VIDX_OUT_W   = 8;
	localparam int DIST_W       = 24;

	typedef enum logic [1:0] {
		MODE_CLEAR,
		MODE_ADD_VERTEX,
		MODE_ADD_EDGE,
		MODE_QUERY
	} mode_t;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_VERTEX = 2'd1;
	localparam logic [1:0] KIND_EDGE   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_USE,
		ST_V_ADDR,
		ST_E_ADDR,
		ST_E_CHK,
		ST_E_RDE,
		ST_E_TEST,
		ST_DIV,
		ST_EMIT
	} state_t;

	// what the shared multiplier is working on
	typedef enum logic [2:0] {
		PH_RR,
		PH_DOT,
		PH_PROJ,
		PH_SQ,
		PH_CROSS,
		PH_HIT
	} phase_t;

endpackage

`default_nettype wire

// ===== sv/segment_snap_query_engine.sv =====
// ----------------------------------------------------------------------------
// segment_snap_query_engine
// Vertex and edge tables with a segment snap query (vertex proximity, then
// x-z edge crossing), computed on one shared multiplier.
// ----------------------------------------------------------------------------
// Clear, add vertex and add edge go from decode straight to the result. A
// query scans the vertex table and then the edge table, passing over skipped
// entries. The work runs on the single multiplier (six to twelve products
// per vertex, six or nine per edge) and on the one-bit-per-cycle divider that
// finds the crossing fraction. The block takes one item at a time;
// in_stall stays high until the item's result is loaded into the output
// register, and the next item may be accepted while that result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_snap_query_engine #(
	parameter int MAX_VERTICES = ssqe_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = ssqe_pkg::MAX_EDGES_DEF,
	parameter int COORD_WIDTH  = ssqe_pkg::COORD_WIDTH_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,

	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [ssqe_pkg::RADIUS_W-1:0]         cfg_data,

	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  [1:0]                            mode,
	input  wire  signed [COORD_WIDTH-1:0]         point_x,
	input  wire  signed [COORD_WIDTH-1:0]         point_y,
	input  wire  signed [COORD_WIDTH-1:0]         point_z,
	input  wire  signed [COORD_WIDTH-1:0]         end_x,
	input  wire  signed [COORD_WIDTH-1:0]         end_y,
	input  wire  signed [COORD_WIDTH-1:0]         end_z,
	input  wire  signed [ssqe_pkg::DIR_W-1:0]     unit_dir_x,
	input  wire  signed [ssqe_pkg::DIR_W-1:0]     unit_dir_y,
	input  wire  signed [ssqe_pkg::DIR_W-1:0]     unit_dir_z,
	input  wire  [ssqe_pkg::FIRST_IDX_W-1:0]      first_index,
	input  wire  [ssqe_pkg::SECOND_IDX_W-1:0]     second_index,

	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic [1:0]                            status,
	output logic [1:0]                            snap_kind,
	output logic [ssqe_pkg::VIDX_OUT_W-1:0]       vertex_index,
	output logic signed [COORD_WIDTH-1:0]         hit_x,
	output logic signed [COORD_WIDTH-1:0]         hit_y,
	output logic signed [COORD_WIDTH-1:0]         hit_z
);

	localparam int CW   = COORD_WIDTH;
	localparam int VIW  = $clog2(MAX_VERTICES);
	localparam int VCW  = $clog2(MAX_VERTICES + 1);
	localparam int EIW  = $clog2(MAX_EDGES);
	localparam int ECW  = $clog2(MAX_EDGES + 1);
	localparam int FCW  = (VCW > ssqe_pkg::FIRST_IDX_W) ? VCW : ssqe_pkg::FIRST_IDX_W;
	localparam int OPW  = (CW + 4 > 32) ? CW + 4 : 32;
	localparam int PW   = 2 * OPW;
	localparam int CS   = (CW > 30) ? CW - 30 : 0;
	localparam int QW   = ssqe_pkg::UFRAC + 1;
	localparam int DW   = ssqe_pkg::DIST_W;
	localparam int FR   = ssqe_pkg::DIR_FRAC;
	localparam int UF   = ssqe_pkg::UFRAC;

	// ---------------- control state ----------------
	ssqe_pkg::state_t state_q, state_d;
	ssqe_pkg::phase_t phase_q, phase_d;
	logic [2:0]       step_q, step_d;

	logic [VCW-1:0]   vcount_q;
	logic [ECW-1:0]   ecount_q;
	logic [VCW-1:0]   idx_q;
	logic [ECW-1:0]   eidx_q;
	logic             out_valid_q;
	logic [ssqe_pkg::RADIUS_W-1:0] snap_radius_q;

	// ---------------- captured item ----------------
	ssqe_pkg::mode_t        mode_q;
	logic signed [CW-1:0]   a_q [3];
	logic signed [CW-1:0]   b_q [3];
	logic signed [ssqe_pkg::DIR_W-1:0] n_q [3];
	logic [FCW-1:0]         fi_q;
	logic [FCW-1:0]         si_q;

	// ---------------- memories ----------------
	logic [CW-1:0]  vx_mem [MAX_VERTICES];
	logic [CW-1:0]  vy_mem [MAX_VERTICES];
	logic [CW-1:0]  vz_mem [MAX_VERTICES];
	logic [VIW-1:0] es_mem [MAX_EDGES];
	logic [VIW-1:0] ee_mem [MAX_EDGES];

	logic signed [CW-1:0] vrd_q [3];
	logic [VIW-1:0]       es_rd_q, ee_rd_q;
	logic                 vrd_en;
	logic [VIW-1:0]       vrd_addr;

	// ---------------- datapath ----------------
	logic signed [OPW-1:0] mul_a, mul_b;
	logic signed [PW-1:0]  prod_q;
	logic signed [PW-1:0]  acc1_q, acc2_q, acc3_q, rr_q;
	logic signed [OPW-1:0] t_q;
	logic signed [DW-1:0]  d_q [3];
	logic signed [CW-1:0]  cx_q, cz_q;
	logic [PW-1:0]         nu_q, du_q;
	logic [QW-1:0]         q_q;
	logic [4:0]            div_cnt_q;

	logic [1:0]              res_status_q, res_kind_q;
	logic [VIW-1:0]          res_vidx_q;
	logic signed [CW-1:0]    res_hit_q [3];
	logic [1:0]              out_status_q, out_kind_q;
	logic [ssqe_pkg::VIDX_OUT_W-1:0] out_vidx_q;
	logic signed [CW-1:0]    out_hit_q [3];

	logic in_fire, emit_fire;
	assign in_fire   = in_valid && !in_stall;
	assign emit_fire = (state_q == ssqe_pkg::ST_EMIT) && (!out_valid_q || !out_stall);

	assign cfg_ready    = 1'b1;
	assign in_stall     = (state_q != ssqe_pkg::ST_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign snap_kind    = out_kind_q;
	assign vertex_index = out_vidx_q;
	assign hit_x        = out_hit_q[0];
	assign hit_y        = out_hit_q[1];
	assign hit_z        = out_hit_q[2];

	// ---------------- derived values ----------------
	logic signed [CW:0] ap [3];
	logic signed [CW:0] bp [3];
	logic signed [CW:0] ba [3];
	logic signed [CW:0] ex, ez, sx, sz, ox, oz;
	logic [1:0]         k3, kd;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ap[k] = (CW+1)'(vrd_q[k]) - (CW+1)'(a_q[k]);
			bp[k] = (CW+1)'(vrd_q[k]) - (CW+1)'(b_q[k]);
			ba[k] = (CW+1)'(b_q[k]) - (CW+1)'(a_q[k]);
		end
		ex = ((CW+1)'(vrd_q[0]) - (CW+1)'(cx_q)) >>> CS;
		ez = ((CW+1)'(vrd_q[2]) - (CW+1)'(cz_q)) >>> CS;
		sx = ba[0] >>> CS;
		sz = ba[2] >>> CS;
		ox = ((CW+1)'(a_q[0]) - (CW+1)'(cx_q)) >>> CS;
		oz = ((CW+1)'(a_q[2]) - (CW+1)'(cz_q)) >>> CS;
		k3 = step_q[1:0];
		kd = (step_q >= 3'd3) ? 2'(step_q - 3'd3) : step_q[1:0];
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (phase_q)
			ssqe_pkg::PH_RR: begin
				mul_a = OPW'(snap_radius_q);
				mul_b = OPW'(snap_radius_q);
			end
			ssqe_pkg::PH_DOT: begin
				mul_a = OPW'(n_q[kd]);
				mul_b = (step_q >= 3'd3) ? OPW'(bp[kd]) : OPW'(ap[kd]);
			end
			ssqe_pkg::PH_PROJ: begin
				mul_a = t_q;
				mul_b = OPW'(n_q[k3]);
			end
			ssqe_pkg::PH_SQ: begin
				mul_a = OPW'(d_q[k3]);
				mul_b = OPW'(d_q[k3]);
			end
			ssqe_pkg::PH_CROSS: begin
				case (step_q)
					3'd0: begin mul_a = OPW'(ex); mul_b = OPW'(oz); end
					3'd1: begin mul_a = OPW'(ez); mul_b = OPW'(ox); end
					3'd2: begin mul_a = OPW'(sx); mul_b = OPW'(oz); end
					3'd3: begin mul_a = OPW'(sz); mul_b = OPW'(ox); end
					3'd4: begin mul_a = OPW'(ez); mul_b = OPW'(sx); end
					default: begin mul_a = OPW'(ex); mul_b = OPW'(sz); end
				endcase
			end
			ssqe_pkg::PH_HIT: begin
				mul_a = OPW'(q_q);
				mul_b = OPW'(ba[k3]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// per-phase tests on the fresh product
	logic signed [PW-1:0] d2_fin, dval, sq_sum, hsum;
	logic [PW-1:0]        dmag, numa_mag, den_mag;
	logic                 dot_fail, proj_fail, sq_pass, cross_fail, div_sat;
	logic [PW-1:0]        nu_sh;
	logic                 v_done, v_skip, e_done, e_skip;

	always_comb begin
		d2_fin    = acc2_q + prod_q;
		dot_fail  = acc1_q[PW-1] || (d2_fin > 0);
		dval      = PW'(ap[k3]) - (prod_q >>> FR);
		dmag      = dval[PW-1] ? PW'(-dval) : PW'(dval);
		proj_fail = dmag > PW'(snap_radius_q);
		sq_sum    = acc3_q + prod_q;
		sq_pass   = sq_sum <= rr_q;
		hsum      = PW'(a_q[k3]) + (prod_q >>> UF);
		if (acc3_q == '0) begin
			cross_fail = 1'b1;
		end else if (acc3_q > 0) begin
			cross_fail = acc1_q < 0 || acc1_q > acc3_q || acc2_q < 0 || acc2_q > acc3_q;
		end else begin
			cross_fail = acc1_q > 0 || acc1_q < acc3_q || acc2_q > 0 || acc2_q < acc3_q;
		end
		numa_mag = acc1_q[PW-1] ? PW'(-acc1_q) : PW'(acc1_q);
		den_mag  = acc3_q[PW-1] ? PW'(-acc3_q) : PW'(acc3_q);
		div_sat  = numa_mag >= den_mag;
		nu_sh    = {nu_q[PW-2:0], 1'b0};
		v_done   = idx_q >= vcount_q;
		v_skip   = FCW'(idx_q) == fi_q;
		e_done   = eidx_q >= ecount_q;
		e_skip   = (FCW'(es_rd_q) == fi_q) || (FCW'(ee_rd_q) == fi_q);
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssqe_pkg::ST_IDLE;
			phase_q <= ssqe_pkg::PH_RR;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		step_d  = step_q;
		unique case (state_q)
			ssqe_pkg::ST_IDLE: begin
				if (in_fire) state_d = ssqe_pkg::ST_DECODE;
			end
			ssqe_pkg::ST_DECODE: begin
				if (mode_q == ssqe_pkg::MODE_QUERY) begin
					state_d = ssqe_pkg::ST_MUL;
					phase_d = ssqe_pkg::PH_RR;
					step_d  = '0;
				end else begin
					state_d = ssqe_pkg::ST_EMIT;
				end
			end
			ssqe_pkg::ST_MUL: state_d = ssqe_pkg::ST_USE;
			ssqe_pkg::ST_USE: begin
				step_d = step_q + 3'd1;
				case (phase_q)
					ssqe_pkg::PH_RR: state_d = ssqe_pkg::ST_V_ADDR;
					ssqe_pkg::PH_DOT: begin
						if (step_q != 3'd5) begin
							state_d = ssqe_pkg::ST_MUL;
						end else if (dot_fail) begin
							state_d = ssqe_pkg::ST_V_ADDR;
						end else begin
							state_d = ssqe_pkg::ST_MUL;
							phase_d = ssqe_pkg::PH_PROJ;
							step_d  = '0;
						end
					end
					ssqe_pkg::PH_PROJ: begin
						if (proj_fail) begin
							state_d = ssqe_pkg::ST_V_ADDR;
						end else if (step_q != 3'd2) begin
							state_d = ssqe_pkg::ST_MUL;
						end else begin
							state_d = ssqe_pkg::ST_MUL;
							phase_d = ssqe_pkg::PH_SQ;
							step_d  = '0;
						end
					end
					ssqe_pkg::PH_SQ: begin
						if (step_q != 3'd2) state_d = ssqe_pkg::ST_MUL;
						else if (sq_pass)   state_d = ssqe_pkg::ST_EMIT;
						else                state_d = ssqe_pkg::ST_V_ADDR;
					end
					ssqe_pkg::PH_CROSS: begin
						if (step_q != 3'd5) state_d = ssqe_pkg::ST_MUL;
						else                state_d = ssqe_pkg::ST_E_TEST;
					end
					ssqe_pkg::PH_HIT: begin
						if (step_q != 3'd2) state_d = ssqe_pkg::ST_MUL;
						else                state_d = ssqe_pkg::ST_EMIT;
					end
					default: state_d = ssqe_pkg::ST_EMIT;
				endcase
			end
			ssqe_pkg::ST_V_ADDR: begin
				if (v_done) begin
					state_d = ssqe_pkg::ST_E_ADDR;
				end else if (!v_skip) begin
					state_d = ssqe_pkg::ST_MUL;
					phase_d = ssqe_pkg::PH_DOT;
					step_d  = '0;
				end
			end
			ssqe_pkg::ST_E_ADDR: begin
				if (e_done) state_d = ssqe_pkg::ST_EMIT;
				else        state_d = ssqe_pkg::ST_E_CHK;
			end
			ssqe_pkg::ST_E_CHK: begin
				if (e_skip) state_d = ssqe_pkg::ST_E_ADDR;
				else        state_d = ssqe_pkg::ST_E_RDE;
			end
			ssqe_pkg::ST_E_RDE: begin
				state_d = ssqe_pkg::ST_MUL;
				phase_d = ssqe_pkg::PH_CROSS;
				step_d  = '0;
			end
			ssqe_pkg::ST_E_TEST: begin
				if (cross_fail) begin
					state_d = ssqe_pkg::ST_E_ADDR;
				end else if (div_sat) begin
					state_d = ssqe_pkg::ST_MUL;
					phase_d = ssqe_pkg::PH_HIT;
					step_d  = '0;
				end else begin
					state_d = ssqe_pkg::ST_DIV;
				end
			end
			ssqe_pkg::ST_DIV: begin
				if (div_cnt_q == 5'(UF - 1)) begin
					state_d = ssqe_pkg::ST_MUL;
					phase_d = ssqe_pkg::PH_HIT;
					step_d  = '0;
				end
			end
			ssqe_pkg::ST_EMIT: begin
				if (emit_fire) state_d = ssqe_pkg::ST_IDLE;
			end
			default: state_d = ssqe_pkg::ST_IDLE;
		endcase
	end

	// ---------------- control registers ----------------
	logic vfull, efull, bad_idx;
	assign vfull   = vcount_q == VCW'(MAX_VERTICES);
	assign efull   = ecount_q == ECW'(MAX_EDGES);
	assign bad_idx = (fi_q >= FCW'(vcount_q)) || (si_q >= FCW'(vcount_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q      <= '0;
			ecount_q      <= '0;
			idx_q         <= '0;
			eidx_q        <= '0;
			out_valid_q   <= 1'b0;
			snap_radius_q <= ssqe_pkg::RADIUS_RESET;
		end else begin
			if (cfg_valid && cfg_ready) snap_radius_q <= cfg_data;

			if (state_q == ssqe_pkg::ST_DECODE) begin
				case (mode_q)
					ssqe_pkg::MODE_CLEAR: begin
						vcount_q <= '0;
						ecount_q <= '0;
					end
					ssqe_pkg::MODE_ADD_VERTEX: begin
						if (!vfull) vcount_q <= vcount_q + 1'b1;
					end
					ssqe_pkg::MODE_ADD_EDGE: begin
						if (!bad_idx && !efull) ecount_q <= ecount_q + 1'b1;
					end
					default: begin
						idx_q  <= '0;
						eidx_q <= '0;
					end
				endcase
			end

			// vertex scan advances on a skip or a failed test
			if ((state_q == ssqe_pkg::ST_V_ADDR && !v_done && v_skip) ||
			    (state_q == ssqe_pkg::ST_USE && state_d == ssqe_pkg::ST_V_ADDR &&
			     phase_q != ssqe_pkg::PH_RR))
				idx_q <= idx_q + 1'b1;

			if ((state_q == ssqe_pkg::ST_E_CHK && e_skip) ||
			    (state_q == ssqe_pkg::ST_E_TEST && cross_fail))
				eidx_q <= eidx_q + 1'b1;

			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------- memories ----------------
	always_comb begin
		vrd_en   = 1'b0;
		vrd_addr = idx_q[VIW-1:0];
		case (state_q)
			ssqe_pkg::ST_V_ADDR: vrd_en = 1'b1;
			ssqe_pkg::ST_E_CHK: begin
				vrd_en   = 1'b1;
				vrd_addr = es_rd_q;
			end
			ssqe_pkg::ST_E_RDE: begin
				vrd_en   = 1'b1;
				vrd_addr = ee_rd_q;
			end
			default: vrd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ssqe_pkg::ST_DECODE && mode_q == ssqe_pkg::MODE_ADD_VERTEX && !vfull) begin
			vx_mem[vcount_q[VIW-1:0]] <= a_q[0];
			vy_mem[vcount_q[VIW-1:0]] <= a_q[1];
			vz_mem[vcount_q[VIW-1:0]] <= a_q[2];
		end
		if (vrd_en) begin
			vrd_q[0] <= vx_mem[vrd_addr];
			vrd_q[1] <= vy_mem[vrd_addr];
			vrd_q[2] <= vz_mem[vrd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ssqe_pkg::ST_DECODE && mode_q == ssqe_pkg::MODE_ADD_EDGE &&
		    !bad_idx && !efull) begin
			es_mem[ecount_q[EIW-1:0]] <= fi_q[VIW-1:0];
			ee_mem[ecount_q[EIW-1:0]] <= si_q[VIW-1:0];
		end
		if (state_q == ssqe_pkg::ST_E_ADDR) begin
			es_rd_q <= es_mem[eidx_q[EIW-1:0]];
			ee_rd_q <= ee_mem[eidx_q[EIW-1:0]];
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= ssqe_pkg::mode_t'(mode);
			a_q[0] <= point_x;
			a_q[1] <= point_y;
			a_q[2] <= point_z;
			b_q[0] <= end_x;
			b_q[1] <= end_y;
			b_q[2] <= end_z;
			n_q[0] <= unit_dir_x;
			n_q[1] <= unit_dir_y;
			n_q[2] <= unit_dir_z;
			fi_q   <= FCW'(first_index);
			si_q   <= FCW'(second_index);
		end

		if (state_q == ssqe_pkg::ST_MUL) prod_q <= PW'(mul_a) * PW'(mul_b);

		case (state_q)
			ssqe_pkg::ST_DECODE: begin
				res_status_q <= ssqe_pkg::STATUS_OK;
				res_kind_q   <= ssqe_pkg::KIND_NONE;
				res_vidx_q   <= '0;
				for (int k = 0; k < 3; k++) res_hit_q[k] <= '0;
				if (mode_q == ssqe_pkg::MODE_ADD_VERTEX) begin
					if (vfull) res_status_q <= ssqe_pkg::STATUS_FULL;
					else       res_vidx_q   <= vcount_q[VIW-1:0];
				end else if (mode_q == ssqe_pkg::MODE_ADD_EDGE) begin
					if (bad_idx)    res_status_q <= ssqe_pkg::STATUS_BAD_INDEX;
					else if (efull) res_status_q <= ssqe_pkg::STATUS_FULL;
				end
			end
			ssqe_pkg::ST_USE: begin
				case (phase_q)
					ssqe_pkg::PH_RR: rr_q <= prod_q;
					ssqe_pkg::PH_DOT: begin
						case (step_q)
							3'd0:    acc1_q <= prod_q;
							3'd1,
							3'd2:    acc1_q <= acc1_q + prod_q;
							3'd3:    acc2_q <= prod_q;
							default: acc2_q <= acc2_q + prod_q;
						endcase
						// d1 is complete and known nonnegative when used
						t_q <= acc1_q[OPW+FR-1:FR];
					end
					ssqe_pkg::PH_PROJ: d_q[k3] <= dval[DW-1:0];
					ssqe_pkg::PH_SQ: begin
						acc3_q <= (step_q == 3'd0) ? prod_q : sq_sum;
						if (step_q == 3'd2 && sq_pass) begin
							res_kind_q <= ssqe_pkg::KIND_VERTEX;
							res_vidx_q <= idx_q[VIW-1:0];
							for (int k = 0; k < 3; k++) res_hit_q[k] <= vrd_q[k];
						end
					end
					ssqe_pkg::PH_CROSS: begin
						case (step_q)
							3'd0:    acc1_q <= prod_q;
							3'd1:    acc1_q <= acc1_q - prod_q;
							3'd2:    acc2_q <= prod_q;
							3'd3:    acc2_q <= acc2_q - prod_q;
							3'd4:    acc3_q <= prod_q;
							default: acc3_q <= acc3_q - prod_q;
						endcase
					end
					ssqe_pkg::PH_HIT: begin
						res_hit_q[k3] <= hsum[CW-1:0];
						if (step_q == 3'd2) begin
							res_kind_q <= ssqe_pkg::KIND_EDGE;
							res_vidx_q <= '0;
						end
					end
					default: rr_q <= rr_q;
				endcase
			end
			ssqe_pkg::ST_E_RDE: begin
				// start vertex of the edge was read last cycle
				cx_q <= vrd_q[0];
				cz_q <= vrd_q[2];
			end
			ssqe_pkg::ST_E_TEST: begin
				nu_q      <= numa_mag;
				du_q      <= den_mag;
				div_cnt_q <= '0;
				q_q       <= div_sat ? QW'(1) << UF : '0;
			end
			ssqe_pkg::ST_DIV: begin
				div_cnt_q <= div_cnt_q + 5'd1;
				if (nu_sh >= du_q) begin
					nu_q <= nu_sh - du_q;
					q_q  <= {q_q[QW-2:0], 1'b1};
				end else begin
					nu_q <= nu_sh;
					q_q  <= {q_q[QW-2:0], 1'b0};
				end
			end
			default: div_cnt_q <= div_cnt_q;
		endcase

		if (emit_fire) begin
			out_status_q <= res_status_q;
			out_kind_q   <= res_kind_q;
			out_vidx_q   <= ssqe_pkg::VIDX_OUT_W'(FCW'(res_vidx_q));
			for (int k = 0; k < 3; k++) out_hit_q[k] <= res_hit_q[k];
		end
	end

endmodule

`default_nettype wire

// ===== verif/segment_snap_query_engine_test.sv =====
// ----------------------------------------------------------------------------
// segment_snap_query_engine_test
// Self-checking bench for the segment snap query engine. A behavioral model of
// the vertex and edge tables predicts every result: vertex snap by projection
// and squared distance, then the x-z crossing test with a bitwise divider.
// Directed items cover extremes, bad indexes, full tables and parallel edges.
// Random scenes of small tables with queries follow, under varied handshake
// idling and snap radius settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_snap_query_engine_test;
	import ssqe_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int NV = MAX_VERTICES_DEF;
	localparam int NE = MAX_EDGES_DEF;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct {
		mode_t mode;
		logic signed [CW-1:0] px, py, pz, ex, ey, ez;
		logic signed [DIR_W-1:0] nx, ny, nz;
		logic [FIRST_IDX_W-1:0] fi;
		logic [SECOND_IDX_W-1:0] si;
	} item_t;

	typedef struct {
		logic [1:0] status;
		logic [1:0] kind;
		logic [VIDX_OUT_W-1:0] vidx;
		logic [CW-1:0] hx, hy, hz;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [RADIUS_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = '0;
	logic signed [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic signed [CW-1:0] end_x = '0, end_y = '0, end_z = '0;
	logic signed [DIR_W-1:0] unit_dir_x = '0, unit_dir_y = '0, unit_dir_z = '0;
	logic [FIRST_IDX_W-1:0] first_index = '0;
	logic [SECOND_IDX_W-1:0] second_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status, snap_kind;
	logic [VIDX_OUT_W-1:0] vertex_index;
	logic signed [CW-1:0] hit_x, hit_y, hit_z;

	segment_snap_query_engine uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.end_x(end_x), .end_y(end_y), .end_z(end_z),
		.unit_dir_x(unit_dir_x), .unit_dir_y(unit_dir_y), .unit_dir_z(unit_dir_z),
		.first_index(first_index), .second_index(second_index),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.snap_kind(snap_kind), .vertex_index(vertex_index),
		.hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z)
	);

	// table model
	longint vert_x[NV], vert_y[NV], vert_z[NV];
	int edge_a[NE], edge_b[NE];
	int vert_count, edge_count;
	logic [RADIUS_W-1:0] radius = RADIUS_RESET;

	result_t pending_results[$];
	int mismatches, items_sent, results_seen;
	int vertex_snaps, edge_hits, full_count, bad_index_count;
	int in_idle_pct, out_idle_pct;
	int quiet_cycles;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic bit near_vertex(item_t it, int i);
		longint a[3], b[3], n[3], p[3], ap[3], bp[3];
		longint d1, d2, t, d, sum, r;
		d1 = 0;
		d2 = 0;
		sum = 0;
		r = longint'(radius);
		a = '{it.px, it.py, it.pz};
		b = '{it.ex, it.ey, it.ez};
		n = '{it.nx, it.ny, it.nz};
		p = '{vert_x[i], vert_y[i], vert_z[i]};
		for (int k = 0; k < 3; k++) begin
			ap[k] = p[k] - a[k];
			bp[k] = p[k] - b[k];
			d1 += n[k] * ap[k];
			d2 += n[k] * bp[k];
		end
		if (d1 < 0 || d2 > 0)
			return 1'b0;
		t = d1 >>> DIR_FRAC;
		for (int k = 0; k < 3; k++) begin
			d = ap[k] - ((t * n[k]) >>> DIR_FRAC);
			if ((d < 0 ? -d : d) > r)
				return 1'b0;
			sum += d * d;
		end
		return sum <= r * r;
	endfunction

	function automatic bit in_unit(longint num, longint den);
		if (den > 0)
			return num >= 0 && num <= den;
		return num <= 0 && num >= den;
	endfunction

	function automatic bit crosses_edge(item_t it, int s, int e, ref result_t res);
		longint ex, ez, sx, sz, ox, oz, numa, numb, den, q, a[3], b[3];
		longint unsigned nu, du;
		a = '{it.px, it.py, it.pz};
		b = '{it.ex, it.ey, it.ez};
		ex = vert_x[e] - vert_x[s];
		ez = vert_z[e] - vert_z[s];
		sx = b[0] - a[0];
		sz = b[2] - a[2];
		ox = a[0] - vert_x[s];
		oz = a[2] - vert_z[s];
		numa = ex * oz - ez * ox;
		numb = sx * oz - sz * ox;
		den = ez * sx - ex * sz;
		if (den == 0 || !in_unit(numa, den) || !in_unit(numb, den))
			return 1'b0;
		nu = numa < 0 ? -numa : numa;
		du = den < 0 ? -den : den;
		q = 0;
		if (nu >= du)
			q = longint'(1) << UFRAC;
		else begin
			for (int k = 0; k < UFRAC; k++) begin
				nu = nu << 1;
				q = q << 1;
				if (nu >= du) begin
					nu -= du;
					q |= 1;
				end
			end
		end
		res.hx = a[0] + ((q * (b[0] - a[0])) >>> UFRAC);
		res.hy = a[1] + ((q * (b[1] - a[1])) >>> UFRAC);
		res.hz = a[2] + ((q * (b[2] - a[2])) >>> UFRAC);
		return 1'b1;
	endfunction

	// applies one item to the table model and returns its result
	function automatic result_t apply_item(item_t it);
		result_t res;
		res = '{STATUS_OK, KIND_NONE, '0, '0, '0, '0};
		case (it.mode)
			MODE_CLEAR: begin
				vert_count = 0;
				edge_count = 0;
			end
			MODE_ADD_VERTEX: begin
				if (vert_count >= NV)
					res.status = STATUS_FULL;
				else begin
					vert_x[vert_count] = it.px;
					vert_y[vert_count] = it.py;
					vert_z[vert_count] = it.pz;
					res.vidx = vert_count;
					vert_count++;
				end
			end
			MODE_ADD_EDGE: begin
				if (it.fi >= vert_count || it.si >= vert_count)
					res.status = STATUS_BAD_INDEX;
				else if (edge_count >= NE)
					res.status = STATUS_FULL;
				else begin
					edge_a[edge_count] = it.fi;
					edge_b[edge_count] = it.si;
					edge_count++;
				end
			end
			default: begin
				for (int i = 0; i < vert_count && res.kind == KIND_NONE; i++) begin
					if (i != it.fi && near_vertex(it, i)) begin
						res.kind = KIND_VERTEX;
						res.vidx = i;
						res.hx = vert_x[i];
						res.hy = vert_y[i];
						res.hz = vert_z[i];
					end
				end
				for (int i = 0; i < edge_count && res.kind == KIND_NONE; i++) begin
					if (edge_a[i] != it.fi && edge_b[i] != it.fi &&
							crosses_edge(it, edge_a[i], edge_b[i], res))
						res.kind = KIND_EDGE;
				end
			end
		endcase
		return res;
	endfunction

	// one transaction on the item channel; in_valid stays high until the
	// next send or an explicit drop
	task automatic send_item(item_t it);
		result_t res;
		if ($urandom_range(0, 99) < in_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= it.mode;
		point_x <= it.px;
		point_y <= it.py;
		point_z <= it.pz;
		end_x <= it.ex;
		end_y <= it.ey;
		end_z <= it.ez;
		unit_dir_x <= it.nx;
		unit_dir_y <= it.ny;
		unit_dir_z <= it.nz;
		first_index <= it.fi;
		second_index <= it.si;
		do
			@(posedge clk);
		while (in_stall);
		res = apply_item(it);
		pending_results.push_back(res);
		items_sent++;
		if (res.kind == KIND_VERTEX) vertex_snaps++;
		if (res.kind == KIND_EDGE) edge_hits++;
		if (res.status == STATUS_FULL) full_count++;
		if (res.status == STATUS_BAD_INDEX) bad_index_count++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_radius(logic [RADIUS_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		radius = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t blank_item(mode_t m);
		item_t it;
		it = '{m, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0};
		return it;
	endfunction

	function automatic item_t vertex_item(longint x, longint y, longint z);
		item_t it;
		it = blank_item(MODE_ADD_VERTEX);
		it.px = x;
		it.py = y;
		it.pz = z;
		return it;
	endfunction

	function automatic item_t edge_item(int a, int b);
		item_t it;
		it = blank_item(MODE_ADD_EDGE);
		it.fi = a;
		it.si = b;
		return it;
	endfunction

	// direction from start to end, scaled to 14 fraction bits
	function automatic item_t query_item(longint ax, longint ay, longint az,
			longint bx, longint by, longint bz, int origin);
		item_t it;
		real dx, dy, dz, len;
		it = blank_item(MODE_QUERY);
		it.px = ax; it.py = ay; it.pz = az;
		it.ex = bx; it.ey = by; it.ez = bz;
		it.fi = origin;
		dx = bx - ax; dy = by - ay; dz = bz - az;
		len = $sqrt(dx * dx + dy * dy + dz * dz);
		if (len > 0.0) begin
			it.nx = $rtoi(dx / len * 16384.0);
			it.ny = $rtoi(dy / len * 16384.0);
			it.nz = $rtoi(dz / len * 16384.0);
		end
		return it;
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.mode = mode_t'($urandom_range(0, 3));
		it.px = $urandom; it.py = $urandom; it.pz = $urandom;
		it.ex = $urandom; it.ey = $urandom; it.ez = $urandom;
		it.nx = $urandom; it.ny = $urandom; it.nz = $urandom;
		it.fi = $urandom;
		it.si = $urandom;
		return it;
	endfunction

	task automatic test_directed();
		item_t it;
		write_radius(RADIUS_RESET);
		send_item(blank_item(MODE_CLEAR));
		send_item(vertex_item(0, 0, 0));
		send_item(vertex_item(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
		send_item(vertex_item(-24'sh800000, -24'sh800000, -24'sh800000));
		send_item(vertex_item('h100, 0, 'h1000));
		send_item(vertex_item('h100, 0, -'h1000));
		send_item(edge_item(511, 0));
		send_item(edge_item(0, 255));
		send_item(edge_item(3, 4));
		send_item(edge_item(1, 2));
		// crossing of the edge at x=256 once the origin is excluded
		send_item(query_item(0, 0, 0, 'h200, 0, 0, 0));
		// no origin: vertex 0 sits on the segment start
		send_item(query_item(0, 0, 0, 'h200, 0, 0, 256));
		// parallel to edge 3-4: zero denominator
		send_item(query_item('h300, 0, 0, 'h300, 0, 'h100, 256));
		// vertex exactly at the segment end, range is inclusive
		send_item(query_item(-'h400, 0, 'h1000, 'h100, 0, 'h1000, 4));
		it = query_item(-24'sh800000, 24'sh7FFFFF, -24'sh800000,
				24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, 511);
		it.nx = -16384; it.ny = 16384; it.nz = -16384;
		send_item(it);
		it.nx = 16384; it.ny = -16384; it.nz = 16384;
		send_item(it);
		write_radius('0);
		send_item(query_item(0, 0, 0, 'h80, 'h80, 'h80, 256));
		write_radius(23'h7FFFFF);
		send_item(query_item(-'h1000, 0, 0, 'h1000, 0, 0, 256));
		send_item(query_item(24'sh7FFFFF, 0, 0, -24'sh800000, 0, 0, 1));
		send_item(blank_item(MODE_CLEAR));
		drain_results();
	endtask

	task automatic test_table_limits();
		write_radius(RADIUS_RESET);
		send_item(blank_item(MODE_CLEAR));
		for (int i = 0; i <= NV; i++)
			send_item(vertex_item(i * 'h40, -i * 'h10, (i % 16) * 'h200));
		for (int i = 0; i <= NE; i++)
			send_item(edge_item(i % NV, (i * 7 + 1) % NV));
		send_item(edge_item(300, 0));
		// a query with both tables full
		send_item(query_item(-'h100, 0, 'h100, 'h5000, 0, 'h1100, 256));
		send_item(blank_item(MODE_CLEAR));
		drain_results();
	endtask

	task automatic random_scene(int budget, ref int used);
		int nv, ne, nq, span, origin;
		longint ax, ay, az, bx, by, bz;
		item_t it;
		span = $urandom_range(0, 3) == 0 ? 'h7FFFF : $urandom_range('h400, 'h8000);
		send_item(blank_item(MODE_CLEAR));
		nv = $urandom_range(1, 12);
		for (int i = 0; i < nv; i++)
			send_item(vertex_item($urandom_range(0, 2 * span) - span,
					$urandom_range(0, span / 4) - span / 8,
					$urandom_range(0, 2 * span) - span));
		ne = $urandom_range(0, 10);
		for (int i = 0; i < ne; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(edge_item($urandom_range(0, 511), $urandom_range(0, 255)));
			else
				send_item(edge_item($urandom_range(0, nv - 1), $urandom_range(0, nv - 1)));
		end
		used += 1 + nv + ne;
		nq = $urandom_range(4, 14);
		for (int i = 0; i < nq && used < budget; i++) begin
			if ($urandom_range(0, 9) == 0)
				it = noise_item();
			else begin
				case ($urandom_range(0, 6))
					0: origin = 256;
					1: origin = $urandom_range(0, 511);
					default: origin = $urandom_range(0, vert_count - 1);
				endcase
				if (origin < vert_count) begin
					ax = vert_x[origin]; ay = vert_y[origin]; az = vert_z[origin];
				end else begin
					ax = $urandom_range(0, 2 * span) - span;
					ay = 0;
					az = $urandom_range(0, 2 * span) - span;
				end
				bx = ax + $urandom_range(0, 2 * span) - span;
				by = ay + $urandom_range(0, span / 8) - span / 16;
				bz = az + $urandom_range(0, 2 * span) - span;
				it = query_item(ax, ay, az, bx, by, bz, origin);
				if ($urandom_range(0, 19) == 0)
					it.fi = $urandom;
			end
			send_item(it);
			used++;
		end
	endtask

	task automatic test_random_traffic(int in_pct, int out_pct, int count);
		int used;
		used = 0;
		in_idle_pct = in_pct;
		out_idle_pct = out_pct;
		while (used < count) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 4))
					0: write_radius('0);
					1: write_radius(23'h7FFFFF);
					2: write_radius(RADIUS_RESET);
					default: write_radius($urandom_range(0, 'h4000));
				endcase
			end
			random_scene(count, used);
		end
		drain_results();
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < out_idle_pct);

	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with none expected (status %0d kind %0d)",
							status, snap_kind);
			end else begin
				exp_res = pending_results.pop_front();
				if (status !== exp_res.status || snap_kind !== exp_res.kind ||
						vertex_index !== exp_res.vidx || hit_x !== exp_res.hx ||
						hit_y !== exp_res.hy || hit_z !== exp_res.hz) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"ERROR: result %0d expected st %0d kind %0d idx %0d ",
								"hit %h %h %h, got st %0d kind %0d idx %0d hit %h %h %h"},
								results_seen, exp_res.status, exp_res.kind,
								exp_res.vidx, exp_res.hx, exp_res.hy, exp_res.hz,
								status, snap_kind, vertex_index, hit_x, hit_y, hit_z);
				end
			end
		end
	end

	// counts cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("ERROR: watchdog expired, %0d results pending",
					pending_results.size());
			$display("segment_snap_query_engine_test NOT OK");
			$finish;
		end
	end

	initial begin
		quiet_cycles = 0;
		in_idle_pct = 0;
		out_idle_pct = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_table_limits();
		test_random_traffic(23, 88, 330);
		test_random_traffic(88, 23, 330);
		test_random_traffic(0, 0, 340);
		repeat (40) @(negedge clk);
		$display("Sent %0d items, checked %0d results.", items_sent, results_seen);
		$display("Vertex snaps %0d, edge crossings %0d, table full %0d, bad index %0d.",
				vertex_snaps, edge_hits, full_count, bad_index_count);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("segment_snap_query_engine_test OK");
		else
			$display("segment_snap_query_engine_test NOT OK");
		$finish;
	end

endmodule
